### sv/rc_pkg.sv
package rc_pkg;

  localparam int VALUE_W    = 31;
  localparam int BASE_W     = 4;
  localparam int DIGIT_W    = 4;
  localparam int DEC_DIGITS = 10;
  localparam int DEC_IDX_W  = 4;
  localparam int DIGIT_CAP  = 31;
  localparam int BUF_IDX_W  = 5;
  localparam int CNT_W      = 6;
  localparam int RECIP_W    = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int MAX_OUT_DIGITS_DEF = 31;

  localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 4'd10;

  // Multiply by this and shift right by DIV10_SHIFT to divide a 31-bit value by ten.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef struct packed {
    logic [DEC_DIGITS-1:0][DIGIT_W-1:0] dec_digits;
    logic [BASE_W-1:0]                  src;
    logic [BASE_W-1:0]                  dst;
    logic                               bad;
  } rc_job_t;

  // Floor of 2^32 divided by the base; the quotient it gives is low by at most one.
  function automatic logic [RECIP_W-1:0] recip(input logic [BASE_W-1:0] base);
    logic [RECIP_W-1:0] r;
    case (base)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/rc_in_if.sv
interface rc_in_if;
  logic                          valid;
  logic                          ready;
  logic [rc_pkg::VALUE_W-1:0]    coded_value;
  logic [rc_pkg::BASE_W-1:0]     source_base;
  logic [rc_pkg::BASE_W-1:0]     target_base;

  modport source (output valid, coded_value, source_base, target_base, input ready);
  modport sink (input valid, coded_value, source_base, target_base, output ready);
endinterface

### sv/rc_out_if.sv
interface rc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rc_pkg::DIGIT_W-1:0]  digit;
  logic                        last_digit;
  logic                        bad_base;

  modport source (output valid, digit, last_digit, bad_base, input ready);
  modport sink (input valid, digit, last_digit, bad_base, output ready);
endinterface

### sv/radix_converter_core.sv
// Converts a number whose decimal digits are read in a source base (2 to 10) into digits of a
// target base, most significant first, with last_digit on the final one. A bad base gives one
// item with bad_base set. The front splits the input into decimal digits, one per cycle by a
// reciprocal multiply, and hands the job through a two-entry queue, so a new item is taken
// while the back is still busy. The back rebuilds the binary value from the decimal digits,
// then finds each target digit on its single reciprocal multiplier, and emits one item per
// cycle while the sink takes them. A result longer than MAX_OUT_DIGITS comes out as that many
// digits of the target base minus one.
module radix_converter_core #(
  parameter int MAX_OUT_DIGITS = rc_pkg::MAX_OUT_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rc_in_if.sink     request,
  rc_out_if.source  result
);

  logic            push_valid;
  logic            push_ready;
  rc_pkg::rc_job_t push_job;
  logic            pop_valid;
  logic            pop_ready;
  rc_pkg::rc_job_t pop_job;

  rc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  rc_back #(
    .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .result    (result)
  );

endmodule

### sv/rc_front.sv
module rc_front (
  input  logic           clk,
  input  logic           rst,
  rc_in_if.sink          request,
  output logic           push_valid,
  input  logic           push_ready,
  output rc_pkg::rc_job_t push_job
);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_SPLIT = 2'd1;
  localparam logic [1:0] F_PUSH  = 2'd2;

  logic [1:0]                     state;
  logic [rc_pkg::VALUE_W-1:0]     val;
  logic [rc_pkg::DEC_IDX_W-1:0]   idx;
  rc_pkg::rc_job_t                job;

  logic [rc_pkg::VALUE_W+31:0]    prod;
  logic [rc_pkg::VALUE_W-1:0]     quo;
  logic [rc_pkg::VALUE_W-1:0]     rem;
  logic                           src_ok;
  logic                           dst_ok;

  assign request.ready = (state == F_IDLE);
  assign push_valid    = (state == F_PUSH);
  assign push_job      = job;

  assign src_ok = (request.source_base >= rc_pkg::BASE_MIN) &&
                  (request.source_base <= rc_pkg::BASE_MAX);
  assign dst_ok = (request.target_base >= rc_pkg::BASE_MIN) &&
                  (request.target_base <= rc_pkg::BASE_MAX);

  always_comb begin
    prod = {32'b0, val} * {{rc_pkg::VALUE_W{1'b0}}, rc_pkg::DIV10_MAGIC};
    quo  = rc_pkg::VALUE_W'(prod >> rc_pkg::DIV10_SHIFT);
    rem  = val - ((quo << 3) + (quo << 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (request.valid) begin
            val            <= request.coded_value;
            idx            <= '0;
            job.dec_digits <= '0;
            job.src        <= request.source_base;
            job.dst        <= request.target_base;
            job.bad        <= !(src_ok && dst_ok);
            state          <= (src_ok && dst_ok) ? F_SPLIT : F_PUSH;
          end
        end
        F_SPLIT: begin
          job.dec_digits[idx] <= rem[rc_pkg::DIGIT_W-1:0];
          val                 <= quo;
          idx                 <= idx + 1'b1;
          if (quo == '0 || idx == rc_pkg::DEC_IDX_W'(rc_pkg::DEC_DIGITS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/rc_queue.sv
module rc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  rc_pkg::rc_job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rc_pkg::rc_job_t pop_job
);

  localparam int PTR_W = $clog2(rc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rc_pkg::QUEUE_DEPTH + 1);

  rc_pkg::rc_job_t   entries [rc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(rc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(rc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(rc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/rc_back.sv
module rc_back #(
  parameter int MAX_OUT_DIGITS = rc_pkg::MAX_OUT_DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  rc_pkg::rc_job_t pop_job,
  rc_out_if.source        result
);

  localparam int EMIT_W = $clog2(MAX_OUT_DIGITS + 1);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_HORNER = 3'd1;
  localparam logic [2:0] B_MUL    = 3'd2;
  localparam logic [2:0] B_DIV    = 3'd3;
  localparam logic [2:0] B_EMIT   = 3'd4;

  logic [2:0]                          state;
  rc_pkg::rc_job_t                     job;
  logic [rc_pkg::VALUE_W-1:0]          acc;
  logic [rc_pkg::DEC_IDX_W-1:0]        hidx;
  logic [rc_pkg::VALUE_W+rc_pkg::RECIP_W-1:0] prod;
  logic [rc_pkg::CNT_W-1:0]            n;
  logic [rc_pkg::DIGIT_W-1:0]          digits [rc_pkg::DIGIT_CAP];
  logic [EMIT_W-1:0]                   emit_total;
  logic [EMIT_W-1:0]                   emit_cnt;
  logic                                sat;
  logic                                ovalid;
  logic [rc_pkg::DIGIT_W-1:0]          odigit;
  logic                                olast;
  logic                                obad;

  logic [rc_pkg::VALUE_W+rc_pkg::BASE_W-1:0] horner_full;
  logic [rc_pkg::VALUE_W-1:0]          q0;
  logic [rc_pkg::VALUE_W+rc_pkg::BASE_W-1:0] qd;
  logic [rc_pkg::VALUE_W-1:0]          rfull;
  logic [rc_pkg::VALUE_W-1:0]          quo;
  logic [rc_pkg::VALUE_W-1:0]          rem;
  logic [rc_pkg::CNT_W-1:0]            n_next;
  logic [rc_pkg::BUF_IDX_W-1:0]        rd_idx;
  logic                                emit_last;
  logic                                slot_free;

  assign pop_ready          = (state == B_IDLE);
  assign result.valid       = ovalid;
  assign result.digit       = odigit;
  assign result.last_digit  = olast;
  assign result.bad_base    = obad;
  assign slot_free          = !ovalid || result.ready;

  always_comb begin
    horner_full = acc * job.src + job.dec_digits[hidx];
    q0          = prod[rc_pkg::VALUE_W+rc_pkg::RECIP_W-1:rc_pkg::RECIP_W];
    qd          = q0 * job.dst;
    rfull       = acc - qd[rc_pkg::VALUE_W-1:0];
    if (rfull >= rc_pkg::VALUE_W'(job.dst)) begin
      quo = q0 + 1'b1;
      rem = rfull - rc_pkg::VALUE_W'(job.dst);
    end else begin
      quo = q0;
      rem = rfull;
    end
    n_next    = n + 1'b1;
    rd_idx    = rc_pkg::BUF_IDX_W'(int'(emit_total) - 1 - int'(emit_cnt));
    emit_last = (emit_cnt == emit_total - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (state == B_DIV) begin
      digits[n[rc_pkg::BUF_IDX_W-1:0]] <= rem[rc_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (ovalid && result.ready && state != B_EMIT) begin
        ovalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            job        <= pop_job;
            acc        <= '0;
            hidx       <= rc_pkg::DEC_IDX_W'(rc_pkg::DEC_DIGITS - 1);
            n          <= '0;
            sat        <= 1'b0;
            emit_cnt   <= '0;
            emit_total <= EMIT_W'(1);
            state      <= pop_job.bad ? B_EMIT : B_HORNER;
          end
        end
        B_HORNER: begin
          acc  <= horner_full[rc_pkg::VALUE_W-1:0];
          hidx <= hidx - 1'b1;
          if (hidx == '0) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod  <= acc * rc_pkg::recip(job.dst);
          state <= B_DIV;
        end
        B_DIV: begin
          acc <= quo;
          n   <= n_next;
          if (quo == '0) begin
            if (int'(n_next) > MAX_OUT_DIGITS) begin
              sat        <= 1'b1;
              emit_total <= EMIT_W'(MAX_OUT_DIGITS);
            end else begin
              emit_total <= EMIT_W'(n_next);
            end
            state <= B_EMIT;
          end else begin
            state <= B_MUL;
          end
        end
        B_EMIT: begin
          if (slot_free) begin
            ovalid   <= 1'b1;
            olast    <= emit_last;
            obad     <= job.bad;
            emit_cnt <= emit_cnt + 1'b1;
            if (job.bad) begin
              odigit <= '0;
            end else if (sat) begin
              odigit <= job.dst - 1'b1;
            end else begin
              odigit <= digits[rd_idx];
            end
            if (emit_last) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### sv/rc_checker.sv
module rc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [3:0] res_digit,
  input logic       res_last,
  input logic       res_bad
);

  // A result item waiting for the sink keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_digit) &&
                                   $stable(res_last) && $stable(res_bad)))
    else $error("result item changed while stalled");

  assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_bad) |-> (res_last && res_digit == 4'd0))
    else $error("bad base item is not a single zero digit");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_digit <= 4'd9))
    else $error("digit out of range");

endmodule

bind radix_converter_core rc_checker u_rc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_digit (result.digit),
  .res_last  (result.last_digit),
  .res_bad   (result.bad_base)
);
